// ===== sv/u8cp_pkg.sv =====
// ----------------------------------------------------------------------------
// u8cp_pkg
// Shared types, codes and lookup tables for the UTF-8 to CP437 converter.
// ----------------------------------------------------------------------------
package u8cp_pkg;

   // decode phase: which part of a multi-byte sequence is expected next
   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_C2       = 3'd1,
      PH_C3       = 3'd2,
      PH_E2       = 3'd3,
      PH_E2_94    = 3'd4,
      PH_E2_95    = 3'd5,
      PH_E2_96    = 3'd6
   } phase_type;

   // lead bytes
   localparam logic [7:0] LEAD_C2 = 8'hC2;
   localparam logic [7:0] LEAD_C3 = 8'hC3;
   localparam logic [7:0] LEAD_E2 = 8'hE2;

   // second bytes after E2 that open a third-byte phase
   localparam logic [7:0] SEL_94 = 8'h94;
   localparam logic [7:0] SEL_95 = 8'h95;
   localparam logic [7:0] SEL_96 = 8'h96;

   // one input beat held in the input register
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } beat_type;

   // table lookup / decode result
   typedef struct packed {
      logic       hit;
      logic [7:0] value;
   } lookup_type;

   // two-byte sequences opened by C2
   function automatic lookup_type lookup_c2(input logic [7:0] key);
      lookup_type r;
      r.hit = 1'b1;
      case (key)
         8'hA1:   r.value = 8'd173;
         8'hBF:   r.value = 8'd168;
         8'hB0:   r.value = 8'd248;
         8'hAC:   r.value = 8'd170;
         8'hBD:   r.value = 8'd250;
         default: begin
            r.hit   = 1'b0;
            r.value = 8'd0;
         end
      endcase
      return r;
   endfunction

   // two-byte sequences opened by C3
   function automatic lookup_type lookup_c3(input logic [7:0] key);
      lookup_type r;
      r.hit = 1'b1;
      case (key)
         8'hB1:   r.value = 8'd164;
         8'h91:   r.value = 8'd165;
         8'hA1:   r.value = 8'd160;
         8'hA9:   r.value = 8'd130;
         8'hAD:   r.value = 8'd161;
         8'hB3:   r.value = 8'd162;
         8'hBA:   r.value = 8'd163;
         8'h81:   r.value = 8'd181;
         8'h89:   r.value = 8'd144;
         8'h8D:   r.value = 8'd214;
         8'h93:   r.value = 8'd224;
         8'h9A:   r.value = 8'd233;
         default: begin
            r.hit   = 1'b0;
            r.value = 8'd0;
         end
      endcase
      return r;
   endfunction

   // box drawing, E2 94 xx
   function automatic lookup_type lookup_e2_94(input logic [7:0] key);
      lookup_type r;
      r.hit = 1'b1;
      case (key)
         8'h82:   r.value = 8'd179;
         8'h94:   r.value = 8'd192;
         8'h8C:   r.value = 8'd218;
         8'h80:   r.value = 8'd196;
         8'h90:   r.value = 8'd191;
         8'h98:   r.value = 8'd217;
         default: begin
            r.hit   = 1'b0;
            r.value = 8'd0;
         end
      endcase
      return r;
   endfunction

   // double-line box drawing, E2 95 xx
   function automatic lookup_type lookup_e2_95(input logic [7:0] key);
      lookup_type r;
      r.hit = 1'b1;
      case (key)
         8'h94:   r.value = 8'd201;
         8'h90:   r.value = 8'd205;
         8'h91:   r.value = 8'd186;
         8'h97:   r.value = 8'd187;
         8'h9A:   r.value = 8'd200;
         8'h9D:   r.value = 8'd188;
         default: begin
            r.hit   = 1'b0;
            r.value = 8'd0;
         end
      endcase
      return r;
   endfunction

   // block elements, E2 96 xx
   function automatic lookup_type lookup_e2_96(input logic [7:0] key);
      lookup_type r;
      r.hit = 1'b1;
      case (key)
         8'h88:   r.value = 8'd219;
         8'h92:   r.value = 8'd177;
         8'h91:   r.value = 8'd176;
         8'h93:   r.value = 8'd178;
         8'h84:   r.value = 8'd220;
         8'h80:   r.value = 8'd223;
         8'h8C:   r.value = 8'd219;
         8'h90:   r.value = 8'd219;
         8'hA0:   r.value = 8'd254;
         default: begin
            r.hit   = 1'b0;
            r.value = 8'd0;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== sv/u8cp_if.sv =====
// ----------------------------------------------------------------------------
// u8cp_if
// Valid/ready stream interfaces for the request and response channels.
// ----------------------------------------------------------------------------

// request channel: one raw UTF-8 byte per beat
interface u8cp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

// response channel: one CP437 byte per beat
interface u8cp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;

   modport source (output valid, output byte_out, input ready);
   modport sink   (input valid, input byte_out, output ready);
endinterface

// ===== sv/u8cp_in_reg.sv =====
// ----------------------------------------------------------------------------
// u8cp_in_reg
// Input register: captures one request beat and holds it until decoded.
// ----------------------------------------------------------------------------
module u8cp_in_reg import u8cp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic [7:0] req_data,
   output logic     req_ready,
   input  logic     advance,
   output beat_type beat
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       take;

   // free when empty or when the held beat moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   // occupancy
   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_data;
      end
   end

   assign beat.valid = valid_ff;
   assign beat.data  = data_ff;

endmodule

// ===== sv/u8cp_decoder.sv =====
// ----------------------------------------------------------------------------
// u8cp_decoder
// Decode phase register plus the lookup of the held byte against the tables.
// ----------------------------------------------------------------------------
module u8cp_decoder import u8cp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] cur_byte,
   output lookup_type dec
);

   phase_type phase_ff, phase_in;

   // phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (advance) begin
         phase_ff <= phase_in;
      end
   end

   // next phase and result for the held byte
   always_comb begin
      phase_in  = PH_IDLE;
      dec.hit   = 1'b0;
      dec.value = 8'd0;
      case (phase_ff)
         PH_C2:    dec = lookup_c2(cur_byte);
         PH_C3:    dec = lookup_c3(cur_byte);
         PH_E2: begin
            if (cur_byte == SEL_94) begin
               phase_in = PH_E2_94;
            end else if (cur_byte == SEL_95) begin
               phase_in = PH_E2_95;
            end else if (cur_byte == SEL_96) begin
               phase_in = PH_E2_96;
            end
         end
         PH_E2_94: dec = lookup_e2_94(cur_byte);
         PH_E2_95: dec = lookup_e2_95(cur_byte);
         PH_E2_96: dec = lookup_e2_96(cur_byte);
         default: begin
            // idle, and the unused code behaves the same
            if (cur_byte == LEAD_C2) begin
               phase_in = PH_C2;
            end else if (cur_byte == LEAD_C3) begin
               phase_in = PH_C3;
            end else if (cur_byte == LEAD_E2) begin
               phase_in = PH_E2;
            end else begin
               dec.hit   = 1'b1;
               dec.value = cur_byte;
            end
         end
      endcase
   end

   // checks
   a_reset_idle: assert property (@(posedge clock) reset |=> phase_ff == PH_IDLE)
      else $error("decode phase not idle after reset");

   a_e2_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_E2 |-> !dec.hit)
      else $error("second byte after E2 produced a result");

   a_close_to_idle: assert property (@(posedge clock) disable iff (reset)
      advance && (phase_ff == PH_C2 || phase_ff == PH_C3 || phase_ff == PH_E2_94 ||
                  phase_ff == PH_E2_95 || phase_ff == PH_E2_96)
      |=> phase_ff == PH_IDLE)
      else $error("closing byte did not return to idle");

   a_hold_phase: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff))
      else $error("decode phase moved without a beat");

endmodule

// ===== sv/u8cp_out_reg.sv =====
// ----------------------------------------------------------------------------
// u8cp_out_reg
// Result register: holds one CP437 byte until the response side takes it.
// ----------------------------------------------------------------------------
module u8cp_out_reg import u8cp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  lookup_type dec,
   output logic       out_free,
   output logic       rsp_valid,
   output logic [7:0] rsp_data,
   input  logic       rsp_ready
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;

   // room for a new result when empty or being drained now
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      if (advance) begin
         valid_in = dec.hit;
      end else begin
         valid_in = valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (advance && dec.hit) begin
         data_ff <= dec.value;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== sv/utf8_to_cp437_converter.sv =====
// ----------------------------------------------------------------------------
// utf8_to_cp437_converter
// Converts a UTF-8 byte stream to code page 437, one byte per beat.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload          beats out per beat in
//   req       in    byte_in  [7:0]   -
//   rsp       out   byte_out [7:0]   0 or 1
//
// One byte is accepted per clock when the response side keeps up.
// A req beat reaches rsp through the input register, then
// phase/table decode into the result register.
// Synchronous active-high reset empties both registers and sets the phase
// to idle. A stalled rsp holds the result; req stalls only when both the
// input and result registers are full and rsp is not ready.
// ----------------------------------------------------------------------------
module utf8_to_cp437_converter import u8cp_pkg::*; (
   input logic        clock,
   input logic        reset,
   u8cp_req_if.sink   req,
   u8cp_rsp_if.source rsp
);

   beat_type   beat;
   lookup_type dec;
   logic       out_free;
   logic       advance;

   // held byte moves into decode when the result register has room
   assign advance = beat.valid && out_free;

   u8cp_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_data  (req.byte_in),
      .req_ready (req.ready),
      .advance   (advance),
      .beat      (beat)
   );

   u8cp_decoder u_decoder (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .cur_byte (beat.data),
      .dec      (dec)
   );

   u8cp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .dec       (dec),
      .out_free  (out_free),
      .rsp_valid (rsp.valid),
      .rsp_data  (rsp.byte_out),
      .rsp_ready (rsp.ready)
   );

endmodule

// ===== tb/u8cp_decode_check.sv =====
// ----------------------------------------------------------------------------
// u8cp_decode_check
// Watches both channels of the UTF-8 to CP437 converter, predicts every
// CP437 byte from the accepted input beats and compares each response beat
// against the oldest prediction. Hands counts back to the testbench top.
// ----------------------------------------------------------------------------
module u8cp_decode_check import u8cp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_byte_in,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_byte_out,
   output int         fail_count,
   output int         pending,
   output int         bytes_in,
   output int         chars_out
);
   timeunit 1ns;
   timeprecision 1ps;

   // outcome of one input byte
   typedef struct {
      logic       emit;
      logic [7:0] glyph;
      phase_type  next;
   } step_type;

   phase_type  phase;
   logic [7:0] cp437_due [$];
   int         fails;
   int         seen_in;
   int         seen_out;

   // closing byte of a sequence looked up in the CP437 glyph tables
   function automatic lookup_type glyph_for(input phase_type ph, input logic [7:0] key);
      lookup_type g;
      g.hit   = 1'b1;
      g.value = 8'd0;
      case (ph)
         PH_C2: begin
            case (key)
               8'hA1:   g.value = 8'd173;
               8'hBF:   g.value = 8'd168;
               8'hB0:   g.value = 8'd248;
               8'hAC:   g.value = 8'd170;
               8'hBD:   g.value = 8'd250;
               default: g.hit = 1'b0;
            endcase
         end
         PH_C3: begin
            case (key)
               8'hB1:   g.value = 8'd164;
               8'h91:   g.value = 8'd165;
               8'hA1:   g.value = 8'd160;
               8'hA9:   g.value = 8'd130;
               8'hAD:   g.value = 8'd161;
               8'hB3:   g.value = 8'd162;
               8'hBA:   g.value = 8'd163;
               8'h81:   g.value = 8'd181;
               8'h89:   g.value = 8'd144;
               8'h8D:   g.value = 8'd214;
               8'h93:   g.value = 8'd224;
               8'h9A:   g.value = 8'd233;
               default: g.hit = 1'b0;
            endcase
         end
         PH_E2_94: begin
            case (key)
               8'h82:   g.value = 8'd179;
               8'h94:   g.value = 8'd192;
               8'h8C:   g.value = 8'd218;
               8'h80:   g.value = 8'd196;
               8'h90:   g.value = 8'd191;
               8'h98:   g.value = 8'd217;
               default: g.hit = 1'b0;
            endcase
         end
         PH_E2_95: begin
            case (key)
               8'h94:   g.value = 8'd201;
               8'h90:   g.value = 8'd205;
               8'h91:   g.value = 8'd186;
               8'h97:   g.value = 8'd187;
               8'h9A:   g.value = 8'd200;
               8'h9D:   g.value = 8'd188;
               default: g.hit = 1'b0;
            endcase
         end
         PH_E2_96: begin
            case (key)
               8'h88:   g.value = 8'd219;
               8'h92:   g.value = 8'd177;
               8'h91:   g.value = 8'd176;
               8'h93:   g.value = 8'd178;
               8'h84:   g.value = 8'd220;
               8'h80:   g.value = 8'd223;
               8'h8C:   g.value = 8'd219;
               8'h90:   g.value = 8'd219;
               8'hA0:   g.value = 8'd254;
               default: g.hit = 1'b0;
            endcase
         end
         default: g.hit = 1'b0;
      endcase
      return g;
   endfunction

   // one byte through the decode phases
   function automatic step_type decode_step(input phase_type ph, input logic [7:0] b);
      step_type   s;
      lookup_type g;
      s.emit  = 1'b0;
      s.glyph = 8'd0;
      s.next  = PH_IDLE;
      case (ph)
         PH_E2: begin
            // second byte only selects the table, never emits
            if (b == SEL_94)
               s.next = PH_E2_94;
            else if (b == SEL_95)
               s.next = PH_E2_95;
            else if (b == SEL_96)
               s.next = PH_E2_96;
         end
         PH_C2, PH_C3, PH_E2_94, PH_E2_95, PH_E2_96: begin
            g       = glyph_for(ph, b);
            s.emit  = g.hit;
            s.glyph = g.value;
         end
         default: begin
            // idle, and the unused phase code behaves the same
            if (b == LEAD_C2)
               s.next = PH_C2;
            else if (b == LEAD_C3)
               s.next = PH_C3;
            else if (b == LEAD_E2)
               s.next = PH_E2;
            else begin
               s.emit  = 1'b1;
               s.glyph = b;
            end
         end
      endcase
      return s;
   endfunction

   // predict on request beats, compare on response beats
   always @(posedge clock) begin : watch
      step_type   s;
      logic [7:0] want;
      if (reset) begin
         phase = PH_IDLE;
         cp437_due.delete();
         fails    = 0;
         seen_in  = 0;
         seen_out = 0;
      end else begin
         if (req_valid && req_ready) begin
            s     = decode_step(phase, req_byte_in);
            phase = s.next;
            if (s.emit)
               cp437_due.push_back(s.glyph);
            seen_in++;
         end
         if (rsp_valid && rsp_ready) begin
            seen_out++;
            if (cp437_due.size() == 0) begin
               $error("byte_out: unexpected beat, expected none, actual %02h", rsp_byte_out);
               fails++;
            end else begin
               want = cp437_due.pop_front();
               if (rsp_byte_out !== want) begin
                  $error("byte_out: expected %02h, actual %02h", want, rsp_byte_out);
                  fails++;
               end
            end
         end
      end
      fail_count <= fails;
      pending    <= cp437_due.size();
      bytes_in   <= seen_in;
      chars_out  <= seen_out;
   end

endmodule

// ===== tb/tb_utf8_to_cp437_converter.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_to_cp437_converter
// Drives the converter with directed UTF-8 sequences and then a long random
// mix of well-formed sequences, broken sequences and raw bytes, with random
// idle bursts on both channels; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_utf8_to_cp437_converter import u8cp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BYTE_TARGET = 1950;
   localparam int CALM_FROM   = 1750;
   localparam int STALL_LIMIT = 1000;

   logic clock;
   logic reset;

   u8cp_req_if req_if ();
   u8cp_rsp_if rsp_if ();

   int fail_count;
   int pending;
   int bytes_in;
   int chars_out;

   int   sent;
   int   intact_seqs;
   int   send_odds;
   logic calm;

   utf8_to_cp437_converter uut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   u8cp_decode_check decode_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_if.valid),
      .req_ready    (req_if.ready),
      .req_byte_in  (req_if.byte_in),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_byte_out (rsp_if.byte_out),
      .fail_count   (fail_count),
      .pending      (pending),
      .bytes_in     (bytes_in),
      .chars_out    (chars_out)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // a listed closing byte for the given table
   function automatic logic [7:0] listed_key(input phase_type ph);
      logic [7:0] k;
      case (ph)
         PH_C2: begin
            case ($urandom_range(4))
               0:       k = 8'hA1;
               1:       k = 8'hBF;
               2:       k = 8'hB0;
               3:       k = 8'hAC;
               default: k = 8'hBD;
            endcase
         end
         PH_C3: begin
            case ($urandom_range(11))
               0:       k = 8'hB1;
               1:       k = 8'h91;
               2:       k = 8'hA1;
               3:       k = 8'hA9;
               4:       k = 8'hAD;
               5:       k = 8'hB3;
               6:       k = 8'hBA;
               7:       k = 8'h81;
               8:       k = 8'h89;
               9:       k = 8'h8D;
               10:      k = 8'h93;
               default: k = 8'h9A;
            endcase
         end
         PH_E2_94: begin
            case ($urandom_range(5))
               0:       k = 8'h82;
               1:       k = 8'h94;
               2:       k = 8'h8C;
               3:       k = 8'h80;
               4:       k = 8'h90;
               default: k = 8'h98;
            endcase
         end
         PH_E2_95: begin
            case ($urandom_range(5))
               0:       k = 8'h94;
               1:       k = 8'h90;
               2:       k = 8'h91;
               3:       k = 8'h97;
               4:       k = 8'h9A;
               default: k = 8'h9D;
            endcase
         end
         default: begin
            case ($urandom_range(8))
               0:       k = 8'h88;
               1:       k = 8'h92;
               2:       k = 8'h91;
               3:       k = 8'h93;
               4:       k = 8'h84;
               5:       k = 8'h80;
               6:       k = 8'h8C;
               7:       k = 8'h90;
               default: k = 8'hA0;
            endcase
         end
      endcase
      return k;
   endfunction

   // one request beat, with an optional idle burst in front of it
   task automatic send_byte(input logic [7:0] b);
      if (!calm && send_odds != 0 && $urandom_range(send_odds - 1) == 0) begin
         req_if.valid   <= 1'b0;
         req_if.byte_in <= 8'($urandom_range(255));
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.byte_in <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent++;
   endtask

   // lead, selector where needed, then a listed or a random closing byte
   task automatic send_sequence(input phase_type ph, input logic intact);
      case (ph)
         PH_C2: send_byte(LEAD_C2);
         PH_C3: send_byte(LEAD_C3);
         default: begin
            send_byte(LEAD_E2);
            if (ph == PH_E2_94)
               send_byte(SEL_94);
            else if (ph == PH_E2_95)
               send_byte(SEL_95);
            else
               send_byte(SEL_96);
         end
      endcase
      if (intact) begin
         send_byte(listed_key(ph));
         intact_seqs++;
      end else
         send_byte(8'($urandom_range(255)));
   endtask

   // response side stalls in bursts, with stretches of none
   initial begin : rsp_stall
      int hold;
      int odds;
      int cycle;
      hold  = 0;
      odds  = 4;
      cycle = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (cycle % 97 == 0) begin
            case ($urandom_range(2))
               0:       odds = 0;
               1:       odds = 3;
               default: odds = 10;
            endcase
         end
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            hold--;
         end else if (!calm && odds != 0 && $urandom_range(odds - 1) == 0) begin
            rsp_if.ready <= 1'b0;
            hold = $urandom_range(1, 18) - 1;
         end else
            rsp_if.ready <= 1'b1;
      end
   end

   // watchdog on cycles without any beat
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // stimulus and verdict
   initial begin : stimulus
      int        kind;
      phase_type ph;
      sent        = 0;
      intact_seqs = 0;
      send_odds   = 4;
      calm        = 1'b0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.byte_in <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes and plain pass-through
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h41);
      // complete two-byte sequences
      send_byte(LEAD_C2); send_byte(8'hA1);
      send_byte(LEAD_C3); send_byte(8'hB1);
      // unlisted closing byte, zero inside a sequence
      send_byte(LEAD_C2); send_byte(8'h00);
      // each three-byte table
      send_byte(LEAD_E2); send_byte(SEL_94); send_byte(8'h82);
      send_byte(LEAD_E2); send_byte(SEL_95); send_byte(8'h9D);
      send_byte(LEAD_E2); send_byte(SEL_96); send_byte(8'hA0);
      // second byte after E2 that selects no table
      send_byte(LEAD_E2); send_byte(8'h41);
      // unlisted third byte
      send_byte(LEAD_E2); send_byte(SEL_96); send_byte(8'hFF);
      // a lead byte inside a sequence is only a continuation
      send_byte(LEAD_C3); send_byte(LEAD_C2);
      send_byte(8'h80);

      // random mix of well-formed sequences, broken sequences and raw bytes
      while (sent < BYTE_TARGET) begin
         if (sent % 100 < 3) begin
            case ($urandom_range(2))
               0:       send_odds = 0;
               1:       send_odds = 3;
               default: send_odds = 8;
            endcase
         end
         calm = (sent >= CALM_FROM);
         case ($urandom_range(4))
            0:       ph = PH_C2;
            1:       ph = PH_C3;
            2:       ph = PH_E2_94;
            3:       ph = PH_E2_95;
            default: ph = PH_E2_96;
         endcase
         kind = $urandom_range(99);
         if (kind < 40)
            send_sequence(ph, 1'b1);
         else if (kind < 52)
            send_sequence(ph, 1'b0);
         else if (kind < 57) begin
            send_byte(LEAD_E2);
            send_byte(8'($urandom_range(255)));
         end else if (kind < 90)
            send_byte(8'($urandom_range(255)));
         else
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      req_if.valid <= 1'b0;

      // drain, then wait for anything stray
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (pending != 0)
         $error("byte_out: %0d expected beats never arrived", pending);
      $display("sent %0d utf-8 bytes (%0d complete sequences), checked %0d cp437 beats",
               bytes_in, intact_seqs, chars_out);
      $display("covered all lead bytes, every table, broken sequences and idle bursts");
      if (fail_count == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
